// ===== rtl/isrb_pkg.sv =====
package isrb_pkg;

  localparam int IDX_MAX_W  = 8;
  localparam int LEN_W      = 6;
  localparam int BLOCK_MAX  = 32;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TIMEOUT  = 1'd1;

  localparam logic [3:0] CMD_RAW_WR   = 4'd0;
  localparam logic [3:0] CMD_RAW_RD   = 4'd1;
  localparam logic [3:0] CMD_QUICK    = 4'd2;
  localparam logic [3:0] CMD_BYTE_RD  = 4'd3;
  localparam logic [3:0] CMD_BYTE_WR  = 4'd4;
  localparam logic [3:0] CMD_BDATA_RD = 4'd5;
  localparam logic [3:0] CMD_BDATA_WR = 4'd6;
  localparam logic [3:0] CMD_WORD_RD  = 4'd7;
  localparam logic [3:0] CMD_WORD_WR  = 4'd8;
  localparam logic [3:0] CMD_PROC     = 4'd9;
  localparam logic [3:0] CMD_BLOCK_RD = 4'd10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODEV   = 2'd1,
    ST_NOSUP   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_FAIL,
    OP_QUICK,
    OP_SETPTR,
    OP_WRPTR,
    OP_RDPTR,
    OP_RDIDX,
    OP_WRIDX,
    OP_WORD,
    OP_BLOCK
  } op_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RDATA,
    BK_WLO,
    BK_WHI,
    BK_BLK
  } bk_state_t;

  // indices already reduced to the register count
  typedef struct packed {
    op_kind_t               kind;
    status_t                status;
    logic                   word_rd;
    logic                   word_wr;
    logic [IDX_MAX_W-1:0]   idx;
    logic [IDX_MAX_W-1:0]   idx1;
    logic [7:0]             dbyte;
    logic [15:0]            dword;
    logic [LEN_W-1:0]       len;
  } op_t;

endpackage

// ===== rtl/i2c_smbus_register_bank_target.sv =====
// channel  dir  handshake              tdata / tuser / tlast
// in       in   in_tvalid/in_tready    bus access or smbus operation
// out      out  out_tvalid/out_tready  status, read data, block length, last
// cfg      in   cfg_valid/cfg_ready    register index and write data
//
// simple writes, pointer loads, quick and failing items: done in back end idle
// byte reads: idle, rdata; word and proc call: idle, wlo, whi (one read port)
// block read: one register file read per byte
// synchronous active-low reset; register file reads as zero via per-entry flags
// a two-item queue between front and back lets input and output stall apart
module i2c_smbus_register_bank_target #(
  parameter int REG_COUNT = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // bus_address, reg_index, data_byte, data_word, block_count, zero pad
  input  logic [isrb_pkg::IN_DATA_W-1:0]       in_tdata,
  // cmd, ten_bit, first_byte
  input  logic [isrb_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_data, byte_count, zero pad
  output logic [isrb_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status
  output logic [isrb_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [isrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [isrb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import isrb_pkg::*;

  op_t  f_op;
  op_t  q_op;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  isrb_front #(
    .REG_COUNT (REG_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_op      (f_op),
    .q_full    (q_full)
  );

  isrb_queue #(
    .WIDTH ($bits(op_t))
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_op),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_op)
  );

  isrb_back #(
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/isrb_ram.sv =====
module isrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/isrb_queue.sv =====
module isrb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_r;
  logic             rd_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign dout    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ===== rtl/isrb_front.sv =====
module isrb_front #(
  parameter int REG_COUNT = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [isrb_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [isrb_pkg::IN_USER_W-1:0]       in_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [isrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [isrb_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 q_push,
  output isrb_pkg::op_t                        q_op,
  input  logic                                 q_full
);
  import isrb_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam logic [11:0] RC_EXT = 12'(REG_COUNT);

  logic [6:0]       target_address_r;
  logic             fault_timeout_r;
  logic [3:0]       cmd;
  logic [6:0]       bus_address;
  logic             ten_bit;
  logic             first_byte;
  logic [7:0]       reg_index;
  logic [7:0]       data_byte;
  logic [15:0]      data_word;
  logic [LEN_W-1:0] block_count;
  logic [IDX_W-1:0] ridx_m;
  logic [IDX_W-1:0] dbyte_m;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx1;
  status_t          status;

  // quotient is at most 15 when the count is 16 or more; the block does not enforce that count
  function automatic logic [IDX_W-1:0] mod_rc(input logic [7:0] v);
    logic [11:0] r;
    r = {4'b0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (RC_EXT << k)) begin
        r = r - (RC_EXT << k);
      end
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] v);
    logic [IDX_W:0] s;
    s = {1'b0, v} + 1'b1;
    return (s == (IDX_W+1)'(REG_COUNT)) ? '0 : s[IDX_W-1:0];
  endfunction

  assign cmd         = in_tuser[3:0];
  assign ten_bit     = in_tuser[4];
  assign first_byte  = in_tuser[5];
  assign bus_address = in_tdata[6:0];
  assign reg_index   = in_tdata[14:7];
  assign data_byte   = in_tdata[22:15];
  assign data_word   = in_tdata[38:23];
  assign block_count = in_tdata[44:39];

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_address_r <= 7'd80;
      fault_timeout_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_ADDRESS: target_address_r <= cfg_data;
        CFG_FAULT_TIMEOUT:  fault_timeout_r  <= cfg_data[0];
        default:            target_address_r <= target_address_r;
      endcase
    end
  end

  assign ridx_m  = mod_rc(reg_index);
  assign dbyte_m = mod_rc(data_byte);
  assign idx     = (cmd == CMD_RAW_WR) ? dbyte_m : ridx_m;
  assign idx1    = inc_wrap(idx);

  always_comb begin
    priority if (fault_timeout_r) begin
      status = ST_TIMEOUT;
    end else if ((cmd == CMD_RAW_WR || cmd == CMD_RAW_RD) && ten_bit) begin
      status = ST_NOSUP;
    end else if (bus_address != target_address_r) begin
      status = ST_NODEV;
    end else if (cmd > CMD_BLOCK_RD) begin
      status = ST_NOSUP;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    q_op         = '0;
    q_op.status  = status;
    q_op.idx     = IDX_MAX_W'(idx);
    q_op.idx1    = IDX_MAX_W'(idx1);
    q_op.dbyte   = data_byte;
    q_op.dword   = data_word;
    q_op.word_rd = (cmd != CMD_WORD_WR);
    q_op.word_wr = (cmd != CMD_WORD_RD);
    q_op.len     = (block_count == '0 || block_count > LEN_W'(BLOCK_MAX)) ?
                   LEN_W'(BLOCK_MAX) : block_count;
    unique case (cmd)
      CMD_RAW_WR:   q_op.kind = first_byte ? OP_SETPTR : OP_WRPTR;
      CMD_RAW_RD:   q_op.kind = OP_RDPTR;
      CMD_QUICK:    q_op.kind = OP_QUICK;
      CMD_BYTE_RD:  q_op.kind = OP_RDPTR;
      CMD_BYTE_WR:  q_op.kind = OP_SETPTR;
      CMD_BDATA_RD: q_op.kind = OP_RDIDX;
      CMD_BDATA_WR: q_op.kind = OP_WRIDX;
      CMD_WORD_RD:  q_op.kind = OP_WORD;
      CMD_WORD_WR:  q_op.kind = OP_WORD;
      CMD_PROC:     q_op.kind = OP_WORD;
      CMD_BLOCK_RD: q_op.kind = OP_BLOCK;
      default:      q_op.kind = OP_FAIL;
    endcase
    if (status != ST_OK) begin
      q_op.kind = OP_FAIL;
    end
  end

endmodule

// ===== rtl/isrb_back.sv =====
module isrb_back #(
  parameter int REG_COUNT = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  isrb_pkg::op_t                        q_op,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [isrb_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [isrb_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);
  import isrb_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);

  bk_state_t        state_r, state_nxt;
  op_t              cur_r;
  logic             ld_cur;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]       lo_r;
  logic             lo_ld;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] baddr_r, baddr_nxt;
  logic [REG_COUNT-1:0] vld_r;
  logic             rd_vld_r;

  logic             re;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;
  logic [7:0]       ram_q;
  logic [7:0]       rdq;

  logic             out_free;
  logic             emit;
  status_t          e_status;
  logic [15:0]      e_data;
  logic [LEN_W-1:0] e_count;
  logic             e_last;
  logic             blk_last;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [15:0]      out_data_r;
  logic [LEN_W-1:0] out_count_r;
  logic             out_last_r;

  logic [IDX_W-1:0] q_idx, q_idx1, c_idx, c_idx1;

  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] v);
    logic [IDX_W:0] s;
    s = {1'b0, v} + 1'b1;
    return (s == (IDX_W+1)'(REG_COUNT)) ? '0 : s[IDX_W-1:0];
  endfunction

  isrb_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign q_idx    = q_op.idx[IDX_W-1:0];
  assign q_idx1   = q_op.idx1[IDX_W-1:0];
  assign c_idx    = cur_r.idx[IDX_W-1:0];
  assign c_idx1   = cur_r.idx1[IDX_W-1:0];
  assign rdq      = rd_vld_r ? ram_q : 8'd0;
  assign out_free = !out_valid_r || out_tready;
  assign blk_last = (LEN_W'(cnt_r + 1'b1) == cur_r.len);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_RDPTR, OP_RDIDX: state_nxt = BK_RDATA;
            OP_WORD:            state_nxt = BK_WLO;
            OP_BLOCK:           state_nxt = BK_BLK;
            default:            state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_RDATA: if (out_free) state_nxt = BK_IDLE;
      BK_WLO:   state_nxt = BK_WHI;
      BK_WHI:   if (out_free) state_nxt = BK_IDLE;
      BK_BLK:   if (out_free && blk_last) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ld_cur    = 1'b0;
    lo_ld     = 1'b0;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_data    = '0;
    e_count   = '0;
    e_last    = 1'b1;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    baddr_nxt = baddr_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_FAIL: begin
              if (out_free) begin
                emit     = 1'b1;
                e_status = q_op.status;
                q_pop    = 1'b1;
              end
            end
            OP_QUICK: begin
              if (out_free) begin
                emit  = 1'b1;
                q_pop = 1'b1;
              end
            end
            OP_SETPTR: begin
              if (out_free) begin
                emit    = 1'b1;
                q_pop   = 1'b1;
                ptr_nxt = q_idx;
              end
            end
            OP_WRPTR: begin
              if (out_free) begin
                emit    = 1'b1;
                q_pop   = 1'b1;
                we      = 1'b1;
                waddr   = ptr_r;
                wdata   = q_op.dbyte;
                ptr_nxt = inc_wrap(ptr_r);
              end
            end
            OP_WRIDX: begin
              if (out_free) begin
                emit    = 1'b1;
                q_pop   = 1'b1;
                we      = 1'b1;
                waddr   = q_idx;
                wdata   = q_op.dbyte;
                ptr_nxt = q_idx1;
              end
            end
            OP_RDPTR: begin
              q_pop   = 1'b1;
              ld_cur  = 1'b1;
              re      = 1'b1;
              raddr   = ptr_r;
              ptr_nxt = inc_wrap(ptr_r);
            end
            OP_RDIDX: begin
              q_pop   = 1'b1;
              ld_cur  = 1'b1;
              re      = 1'b1;
              raddr   = q_idx;
              ptr_nxt = q_idx1;
            end
            OP_WORD: begin
              q_pop  = 1'b1;
              ld_cur = 1'b1;
              re     = 1'b1;
              raddr  = q_idx;
            end
            OP_BLOCK: begin
              q_pop     = 1'b1;
              ld_cur    = 1'b1;
              re        = 1'b1;
              raddr     = q_idx;
              cnt_nxt   = '0;
              baddr_nxt = q_idx1;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_RDATA: begin
        if (out_free) begin
          emit   = 1'b1;
          e_data = {8'd0, rdq};
        end
      end
      BK_WLO: begin
        // low byte read is done, so the low write may go ahead
        lo_ld = 1'b1;
        re    = 1'b1;
        raddr = c_idx1;
        if (cur_r.word_wr) begin
          we    = 1'b1;
          waddr = c_idx;
          wdata = cur_r.dword[7:0];
        end
      end
      BK_WHI: begin
        if (out_free) begin
          emit    = 1'b1;
          e_data  = cur_r.word_rd ? {rdq, lo_r} : 16'd0;
          ptr_nxt = inc_wrap(c_idx1);
          if (cur_r.word_wr) begin
            we    = 1'b1;
            waddr = c_idx1;
            wdata = cur_r.dword[15:8];
          end
        end
      end
      BK_BLK: begin
        if (out_free) begin
          emit    = 1'b1;
          e_data  = {8'd0, rdq};
          e_count = cur_r.len;
          e_last  = blk_last;
          if (blk_last) begin
            ptr_nxt = baddr_r;
          end else begin
            re        = 1'b1;
            raddr     = baddr_r;
            baddr_nxt = inc_wrap(baddr_r);
            cnt_nxt   = LEN_W'(cnt_r + 1'b1);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      ptr_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    baddr_r <= baddr_nxt;
    if (ld_cur) begin
      cur_r <= q_op;
    end
    if (lo_ld) begin
      lo_r <= rdq;
    end
    if (re) begin
      rd_vld_r <= vld_r[raddr];
    end
    if (emit) begin
      out_status_r <= e_status;
      out_data_r   <= e_data;
      out_count_r  <= e_count;
      out_last_r   <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_data_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result produced while output register busy");

  a_blk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_BLK) |-> (cnt_r < cur_r.len))
    else $error("block counter past length");

  a_rdata_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RDATA && $past(state_r) != BK_RDATA) |-> $past(re))
    else $error("read data wait without read");

  a_no_write_read_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("write and read hit the same register");
`endif

endmodule

// ===== tb/sv/i2c_smbus_register_bank_target_tb.sv =====
module i2c_smbus_register_bank_target_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isrb_pkg::*;

  localparam logic [3:0] CMD_UNSUP_FIRST = 4'd11;
  localparam logic [3:0] CMD_UNSUP_LAST  = 4'd15;
  localparam logic [6:0] ADDR_RESET      = 7'd80;
  localparam logic [6:0] ADDR_TOP        = 7'h7f;
  localparam logic [6:0] ADDR_BOTTOM     = 7'h00;
  localparam int         QUIET_LIMIT     = 3000;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [6:0]  bus_address;
    logic        ten_bit;
    logic        first_byte;
    logic [7:0]  reg_index;
    logic [7:0]  data_byte;
    logic [15:0] data_word;
    logic [5:0]  block_count;
  } access_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] read_data;
    logic [5:0]  byte_count;
    logic        last;
  } reply_t;

  typedef struct packed {
    access_t     acc;
    logic        typed;
    status_t     status;
    logic [15:0] read_data;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [7:0] bank_regs [0:255];
  logic [7:0] bank_pointer;
  logic [6:0] own_address;
  logic       timeout_fault;

  reply_t      fresh_replies[$];
  reply_t      pending_replies[$];
  script_row_t script[$];

  int send_idle_pct = 23;
  int recv_idle_pct = 78;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int n_access = 0;
  int n_replies = 0;
  int n_blocks = 0;

  i2c_smbus_register_bank_target #(
    .REG_COUNT(256)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic reply_t make_reply(status_t st, logic [15:0] rd, logic [5:0] cnt,
                                        logic lst);
    reply_t r;
    r.status = st;
    r.read_data = rd;
    r.byte_count = cnt;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_access(input access_t a);
    logic [7:0] idx;
    logic [7:0] hi;
    logic [15:0] rd;
    int len;
    fresh_replies.delete();
    idx = a.reg_index;
    hi = idx + 8'd1;
    rd = '0;
    if (timeout_fault) begin
      fresh_replies.push_back(make_reply(ST_TIMEOUT, '0, '0, 1'b1));
    end else if (a.cmd <= CMD_RAW_RD && a.ten_bit) begin
      fresh_replies.push_back(make_reply(ST_NOSUP, '0, '0, 1'b1));
    end else if (a.bus_address != own_address) begin
      fresh_replies.push_back(make_reply(ST_NODEV, '0, '0, 1'b1));
    end else begin
      case (a.cmd)
        CMD_RAW_WR: begin
          if (a.first_byte) begin
            bank_pointer = a.data_byte;
          end else begin
            bank_regs[bank_pointer] = a.data_byte;
            bank_pointer = bank_pointer + 8'd1;
          end
        end
        CMD_RAW_RD, CMD_BYTE_RD: begin
          rd = {8'd0, bank_regs[bank_pointer]};
          bank_pointer = bank_pointer + 8'd1;
        end
        CMD_QUICK: ;
        CMD_BYTE_WR: bank_pointer = idx;
        CMD_BDATA_RD: begin
          rd = {8'd0, bank_regs[idx]};
          bank_pointer = hi;
        end
        CMD_BDATA_WR: begin
          bank_regs[idx] = a.data_byte;
          bank_pointer = hi;
        end
        CMD_WORD_RD, CMD_WORD_WR, CMD_PROC: begin
          if (a.cmd != CMD_WORD_WR) rd = {bank_regs[hi], bank_regs[idx]};
          if (a.cmd != CMD_WORD_RD) begin
            bank_regs[idx] = a.data_word[7:0];
            bank_regs[hi] = a.data_word[15:8];
          end
          bank_pointer = idx + 8'd2;
        end
        CMD_BLOCK_RD: begin
          len = (a.block_count == 0 || a.block_count > BLOCK_MAX) ? BLOCK_MAX
                                                                   : a.block_count;
          for (int i = 0; i < len; i++) begin
            fresh_replies.push_back(make_reply(ST_OK, {8'd0, bank_regs[8'(idx + i)]},
                                               6'(len), i == len - 1));
          end
          bank_pointer = 8'(idx + len);
          n_blocks++;
        end
        default: begin
          fresh_replies.push_back(make_reply(ST_NOSUP, '0, '0, 1'b1));
        end
      endcase
      if (fresh_replies.size() == 0) begin
        fresh_replies.push_back(make_reply(ST_OK, rd, '0, 1'b1));
      end
    end
  endtask

  task automatic send_access(input access_t a, input logic typed, input status_t st,
                             input logic [15:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'd0, a.block_count, a.data_word, a.data_byte, a.reg_index,
                 a.bus_address};
    in_tuser <= {a.first_byte, a.ten_bit, a.cmd};
    do @(posedge clk); while (!in_tready);
    n_access++;
    predict_access(a);
    if (typed) begin
      pending_replies.push_back(make_reply(st, rd, '0, 1'b1));
    end else begin
      foreach (fresh_replies[i]) pending_replies.push_back(fresh_replies[i]);
    end
  endtask

  function automatic access_t wellformed_access(logic [3:0] cmd);
    access_t a;
    a.cmd = cmd;
    a.bus_address = own_address;
    a.ten_bit = (cmd <= CMD_RAW_RD) ? 1'b0 : 1'($urandom_range(1));
    a.first_byte = 1'($urandom_range(1));
    a.reg_index = $urandom_range(1) ? 8'($urandom_range(255))
                                    : 8'(8'hf8 + $urandom_range(15));
    a.data_byte = 8'($urandom_range(255));
    a.data_word = 16'($urandom_range(65535));
    a.block_count = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                             : 6'($urandom_range(1, 4));
    return a;
  endfunction

  task automatic send_random(input int count);
    access_t a;
    int pick;
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // write message: pointer byte then a run of data bytes
        a = wellformed_access(CMD_RAW_WR);
        a.first_byte = 1'b1;
        send_access(a, 1'b0, ST_OK, '0);
        burst = $urandom_range(1, 5);
        repeat (burst) begin
          a = wellformed_access(CMD_RAW_WR);
          a.first_byte = 1'b0;
          send_access(a, 1'b0, ST_OK, '0);
        end
        k += burst + 1;
      end else if (pick < 32) begin
        a = wellformed_access(4'($urandom_range(CMD_UNSUP_LAST)));
        a.bus_address = $urandom_range(1) ? 7'($urandom_range(127)) : own_address;
        a.ten_bit = 1'($urandom_range(1));
        send_access(a, 1'b0, ST_OK, '0);
        k++;
      end else begin
        a = wellformed_access(4'($urandom_range(CMD_BLOCK_RD)));
        send_access(a, 1'b0, ST_OK, '0);
        k++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TARGET_ADDRESS) begin
      own_address = val;
    end else begin
      timeout_fault = val[0];
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [6:0] addr, input logic fault);
    settle();
    write_reg(CFG_TARGET_ADDRESS, addr);
    write_reg(CFG_FAULT_TIMEOUT, {6'd0, fault});
    cfg_valid <= 1'b0;
  endtask

  function automatic script_row_t row(logic [3:0] cmd, logic [6:0] addr, logic tenb,
                                      logic first, logic [7:0] idx, logic [7:0] db,
                                      logic [15:0] dw, logic [5:0] cnt, logic typed,
                                      status_t st, logic [15:0] rd);
    script_row_t r;
    r.acc.cmd = cmd;
    r.acc.bus_address = addr;
    r.acc.ten_bit = tenb;
    r.acc.first_byte = first;
    r.acc.reg_index = idx;
    r.acc.data_byte = db;
    r.acc.data_word = dw;
    r.acc.block_count = cnt;
    r.typed = typed;
    r.status = st;
    r.read_data = rd;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at reply %0d, %s: got 0x%0h, want 0x%0h", n_replies, what,
             got, want);
    mismatches++;
  endtask

  // reply checker, receiver stalls and the quiet-cycle counter
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("reply with none expected", out_tdata[15:0], 0);
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser !== want.status) flag_mismatch("status", out_tuser, want.status);
        if (out_tdata[15:0] !== want.read_data)
          flag_mismatch("read_data", out_tdata[15:0], want.read_data);
        if (out_tdata[21:16] !== want.byte_count)
          flag_mismatch("byte_count", out_tdata[21:16], want.byte_count);
        if (out_tlast !== want.last) flag_mismatch("last", out_tlast, want.last);
      end
      n_replies++;
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    foreach (bank_regs[i]) bank_regs[i] = 8'd0;
    bank_pointer = 8'd0;
    own_address = ADDR_RESET;
    timeout_fault = 1'b0;

    // reset state, error codes and check order
    script.push_back(row(CMD_BDATA_RD, ADDR_RESET, 0, 0, 8'hff, 0, 0, 0, 1, ST_OK, 0));
    script.push_back(row(CMD_RAW_WR, ADDR_RESET, 1, 1, 0, 8'hff, 0, 0, 1, ST_NOSUP, 0));
    script.push_back(row(CMD_RAW_RD, ADDR_BOTTOM, 0, 0, 0, 0, 0, 0, 1, ST_NODEV, 0));
    script.push_back(row(CMD_UNSUP_LAST, ADDR_TOP, 0, 0, 0, 0, 0, 0, 1, ST_NODEV, 0));
    script.push_back(row(CMD_UNSUP_FIRST, ADDR_RESET, 0, 0, 0, 0, 0, 0, 1, ST_NOSUP, 0));
    script.push_back(row(CMD_QUICK, ADDR_RESET, 1, 0, 0, 0, 0, 0, 1, ST_OK, 0));
    script.push_back(row(CMD_WORD_RD, ADDR_RESET, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0));
    // write message across the top of the bank
    script.push_back(row(CMD_RAW_WR, ADDR_RESET, 0, 1, 0, 8'hfe, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_RAW_WR, ADDR_RESET, 0, 0, 0, 8'hff, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_RAW_WR, ADDR_RESET, 0, 0, 0, 8'ha5, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_RAW_WR, ADDR_RESET, 0, 0, 0, 8'h3c, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_BYTE_WR, ADDR_RESET, 0, 0, 8'hfe, 0, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_BYTE_RD, ADDR_RESET, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_RAW_RD, ADDR_RESET, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_BDATA_WR, ADDR_RESET, 0, 0, 8'hff, 8'h80, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_BDATA_RD, ADDR_RESET, 0, 0, 8'hff, 0, 0, 0, 0, ST_OK, 0));
    // word access wrapping from the last register to the first, then proc calls
    script.push_back(row(CMD_WORD_WR, ADDR_RESET, 0, 0, 8'hff, 0, 16'hffff, 0, 0,
                         ST_OK, 0));
    script.push_back(row(CMD_WORD_RD, ADDR_RESET, 0, 0, 8'hff, 0, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_PROC, ADDR_RESET, 0, 0, 8'h10, 0, 16'h1234, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_PROC, ADDR_RESET, 0, 0, 8'h10, 0, 16'h0000, 0, 0, ST_OK, 0));
    // block reads: zero length, oversize length, single byte, wrap, wrong address
    script.push_back(row(CMD_BLOCK_RD, ADDR_RESET, 0, 0, 8'hfe, 0, 0, 0, 0, ST_OK, 0));
    script.push_back(row(CMD_BLOCK_RD, ADDR_RESET, 0, 0, 8'h00, 0, 0, 6'h3f, 0, ST_OK, 0));
    script.push_back(row(CMD_BLOCK_RD, ADDR_RESET, 0, 0, 8'hf0, 0, 0, 1, 0, ST_OK, 0));
    script.push_back(row(CMD_BLOCK_RD, ADDR_RESET, 0, 0, 8'hff, 0, 0, 32, 0, ST_OK, 0));
    script.push_back(row(CMD_BLOCK_RD, 7'd81, 0, 0, 8'h80, 0, 0, 5, 1, ST_NODEV, 0));
    script.push_back(row(CMD_RAW_RD, ADDR_RESET, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_access(script[i].acc, script[i].typed, script[i].status, script[i].read_data);
    end
    send_random(70);

    reconfigure(ADDR_TOP, 1'b1);
    send_random(15);

    send_idle_pct = 78;
    recv_idle_pct = 23;
    reconfigure(ADDR_TOP, 1'b0);
    send_random(50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    reconfigure(ADDR_BOTTOM, 1'b0);
    hold_request <= 1'b1;
    send_random(60);

    settle();
    $display("covered %0d accesses and %0d replies, %0d block reads,", n_access,
             n_replies, n_blocks);
    $display("target addresses 80, 127 and 0, the timeout fault and all error codes");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
